[rtl/utf8_stream_decoder_assert.svh]
// assertion helpers for the utf8 stream decoder
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// property checked on every rising edge of clk, off while rst is high
`define UTF8SD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be true
`define UTF8SD_NEVER(lbl, cond, msg) \
  `UTF8SD_ASSERT(lbl, !(cond), msg)

`endif

[rtl/utf8sd_pkg.sv]
`timescale 1ns / 1ps

package utf8sd_pkg;

  localparam int CP_W    = 31;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int LEVEL_W = QPTR_W + 1;

  localparam logic [CP_W-1:0] QMARK = CP_W'(63);

  // lead byte patterns, mask and expected bits
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] LEAD5_MASK = 8'hFC;
  localparam logic [7:0] LEAD5_CODE = 8'hF8;
  localparam logic [7:0] LEAD6_MASK = 8'hFE;
  localparam logic [7:0] LEAD6_CODE = 8'hFC;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;
  localparam logic [7:0] PAY_MASK   = 8'h3F;

  typedef enum logic [1:0] {
    KIND_ASCII,
    KIND_LEAD,
    KIND_BAD
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [4:0] pay;
    logic [2:0] rem;
  } start_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            last_of_item;
    logic            last_of_string;
  } result_t;

  // results produced by one byte transfer
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               room;
  } q_stat_t;

  function automatic start_t classify(input logic [7:0] b);
    start_t s;
    s.kind = KIND_LEAD;
    s.pay  = 5'd0;
    s.rem  = 3'd0;
    if (!b[7]) begin
      s.kind = KIND_ASCII;
    end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      s.pay = b[4:0];
      s.rem = 3'd1;
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      s.pay = {1'b0, b[3:0]};
      s.rem = 3'd2;
    end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
      s.pay = {2'b0, b[2:0]};
      s.rem = 3'd3;
    end else if ((b & LEAD5_MASK) == LEAD5_CODE) begin
      s.pay = {3'b0, b[1:0]};
      s.rem = 3'd4;
    end else if ((b & LEAD6_MASK) == LEAD6_CODE) begin
      s.pay = {4'b0, b[0]};
      s.rem = 3'd5;
    end else begin
      s.kind = KIND_BAD;
    end
    return s;
  endfunction

endpackage

[rtl/utf8sd_byte_if.sv]
`timescale 1ns / 1ps

interface utf8sd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_string;

  modport source (output valid, byte_in, end_of_string, input ready);
  modport sink (input valid, byte_in, end_of_string, output ready);
endinterface

[rtl/utf8sd_cp_if.sv]
`timescale 1ns / 1ps

interface utf8sd_cp_if;
  logic        valid;
  logic        ready;
  logic [30:0] code_point;
  logic        last_of_item;
  logic        last_of_string;

  modport source (output valid, code_point, last_of_item, last_of_string, input ready);
  modport sink (input valid, code_point, last_of_item, last_of_string, output ready);
endinterface

[rtl/utf8sd_core.sv]
`timescale 1ns / 1ps

module utf8sd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        byte_in,
  input  logic              end_of_string,
  output utf8sd_pkg::push_t push
);
  import utf8sd_pkg::*;

  logic [CP_W-1:0] partial_value;
  logic [CP_W-1:0] partial_value_next;
  logic [2:0]      bytes_remaining;
  logic [2:0]      bytes_remaining_next;

  start_t          st;
  logic            in_seq;
  logic            is_cont;
  logic [CP_W-1:0] shifted;
  logic [2:0]      rem_dec;
  logic            st_emit;
  logic [CP_W-1:0] st_val;
  logic [1:0]      n;
  logic [CP_W-1:0] v0;
  logic [CP_W-1:0] v1;

  assign st      = classify(byte_in);
  assign in_seq  = (bytes_remaining != 3'd0);
  assign is_cont = ((byte_in & CONT_MASK) == CONT_CODE);
  assign shifted = {partial_value[CP_W-7:0], byte_in[5:0] & PAY_MASK[5:0]};
  assign rem_dec = bytes_remaining - 3'd1;

  // what a byte gives when it starts a new character
  always_comb begin
    st_emit = 1'b1;
    st_val  = QMARK;
    case (st.kind)
      KIND_ASCII: st_val = CP_W'(byte_in);
      KIND_LEAD: begin
        st_emit = end_of_string;
        st_val  = CP_W'(st.pay);
      end
      default: st_val = QMARK;
    endcase
  end

  // results of this byte
  always_comb begin
    n  = 2'd0;
    v0 = st_val;
    v1 = st_val;
    if (in_seq && is_cont) begin
      v0 = shifted;
      n  = (rem_dec == 3'd0 || end_of_string) ? 2'd1 : 2'd0;
    end else if (in_seq) begin
      // broken sequence: flag it, then restart on the same byte
      v0 = QMARK;
      n  = st_emit ? 2'd2 : 2'd1;
    end else begin
      n  = st_emit ? 2'd1 : 2'd0;
    end

    push.n                 = fire ? n : 2'd0;
    push.r0.code_point     = v0;
    push.r0.last_of_item   = (n == 2'd1);
    push.r0.last_of_string = (n == 2'd1) && end_of_string;
    push.r1.code_point     = v1;
    push.r1.last_of_item   = 1'b1;
    push.r1.last_of_string = end_of_string;
  end

  always_comb begin
    partial_value_next   = partial_value;
    bytes_remaining_next = bytes_remaining;
    if (end_of_string) begin
      partial_value_next   = '0;
      bytes_remaining_next = 3'd0;
    end else if (in_seq && is_cont) begin
      if (rem_dec == 3'd0) begin
        partial_value_next = '0;
      end else begin
        partial_value_next = shifted;
      end
      bytes_remaining_next = rem_dec;
    end else if (st.kind == KIND_LEAD) begin
      partial_value_next   = CP_W'(st.pay);
      bytes_remaining_next = st.rem;
    end else begin
      partial_value_next   = '0;
      bytes_remaining_next = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value   <= '0;
      bytes_remaining <= 3'd0;
    end else if (fire) begin
      partial_value   <= partial_value_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

[rtl/utf8sd_outq.sv]
`timescale 1ns / 1ps

module utf8sd_outq (
  input  logic                clk,
  input  logic                rst,
  input  utf8sd_pkg::push_t   push,
  input  logic                pop,
  output utf8sd_pkg::result_t head,
  output utf8sd_pkg::q_stat_t stat
);
  import utf8sd_pkg::*;

  result_t             entries [QDEPTH];
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   wr_ptr_plus;
  logic [LEVEL_W-1:0]  level;
  logic [LEVEL_W-1:0]  level_next;

  assign wr_ptr_plus = wr_ptr + QPTR_W'(1);
  assign level_next  = level + LEVEL_W'(push.n) - LEVEL_W'(pop);
  assign head        = entries[rd_ptr];
  assign stat.level  = level;
  assign stat.room   = (level <= LEVEL_W'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      entries[wr_ptr_plus] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      level <= level_next;
    end
  end

endmodule

[rtl/utf8_stream_decoder.sv]
`timescale 1ns / 1ps

// utf8 stream decoder: takes one byte per transfer on din and gives decoded code points
// (up to 31 bits, old 5- and 6-byte forms included) on dout. a byte is decoded in the
// cycle it is transferred and its results are written into the result queue. din takes a
// byte every cycle as long as the 4-entry result queue has room for two results, so the
// rate is one byte per cycle while dout keeps up; a byte that breaks a sequence and is
// itself a full character yields two results and uses two queue slots, so such bytes
// drain at the output's one result per cycle. lead and continuation bytes that do not
// finish a character give no result. malformed input gives '?' (63); end_of_string on
// an unfinished sequence gives the bits gathered so far. last_of_item marks the final
// result of a byte, last_of_string the final result of a string.
module utf8_stream_decoder (
  input logic         clk,
  input logic         rst,
  utf8sd_byte_if.sink din,
  utf8sd_cp_if.source dout
);
  import utf8sd_pkg::*;

  logic    in_fire;
  logic    out_fire;
  push_t   push;
  result_t head;
  q_stat_t q_stat;

  // byte side: accept while two queue slots are free
  assign din.ready = q_stat.room;
  assign in_fire   = din.valid && din.ready;

  // decode state and per-byte result generation
  utf8sd_core u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (in_fire),
    .byte_in       (din.byte_in),
    .end_of_string (din.end_of_string),
    .push          (push)
  );

  // result queue between decode and output transfer
  utf8sd_outq u_outq (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (out_fire),
    .head (head),
    .stat (q_stat)
  );

  assign dout.valid          = (q_stat.level != '0);
  assign dout.code_point     = head.code_point;
  assign dout.last_of_item   = head.last_of_item;
  assign dout.last_of_string = head.last_of_string;
  assign out_fire            = dout.valid && dout.ready;

  `include "utf8_stream_decoder_assert.svh"

  // queue never holds more than its depth
  `UTF8SD_NEVER(a_level_max, q_stat.level > LEVEL_W'(QDEPTH), "result queue overflow")
  // only the second of two results closes the byte
  `UTF8SD_NEVER(a_two_last, (push.n == 2'd2) && push.r0.last_of_item, "early last_of_item")
  // results are only produced for an accepted byte
  `UTF8SD_NEVER(a_push_idle, !in_fire && (push.n != 2'd0), "result without byte transfer")
  // after a push, dout is valid next cycle
  `UTF8SD_ASSERT(a_push_vis, (push.n != 2'd0) |=> dout.valid, "pushed result not visible")

endmodule
